// ----- hw/rtl/tlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants for the two-level page map insert block.
// ----------------------------------------------------------------------------
package tlpm_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = 10;
  localparam int PERM_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;

  // directory entry bits that mark a superpage (present + page size)
  localparam logic [PERM_W-1:0] SUPER_BITS = 12'h081;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_BASE = 2'd0,
    REG_USER_PERMS  = 2'd1,
    REG_POOL_BASE   = 2'd2
  } cfg_reg_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_KERNEL    = 3'd1,
    STS_SUPERPAGE = 3'd2,
    STS_MAPPED    = 3'd3,
    STS_NO_TABLE  = 3'd4
  } map_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;      // clearing pass: zero one directory entry and one bitmap row
    logic accept;     // capture request, launch directory read
    logic dir_stage;  // evaluate directory entry, launch bitmap read
    logic map_stage;  // final check, commit writes, register result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage

// ----- hw/rtl/tlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpm_ctrl
// Sequencer: clearing pass after reset, then three steps per request.
// ----------------------------------------------------------------------------
module tlpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tlpm_pkg::dp_sts_t sts,
  output tlpm_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import tlpm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_MAP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DIR;
      S_DIR:   state_nxt = S_MAP;
      S_MAP:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.clear     = (state_r == S_CLEAR);
    cmd.accept    = (state_r == S_IDLE) && start;
    cmd.dir_stage = (state_r == S_DIR);
    cmd.map_stage = (state_r == S_MAP);
  end

  assign busy = busy_r;

endmodule

// ----- hw/rtl/tlpm_dp.sv -----
// ----------------------------------------------------------------------------
// tlpm_dp
// Datapath: config registers, page directory, table-entry mapped bitmap,
// table allocation counter and result registers.
// ----------------------------------------------------------------------------
module tlpm_dp #(
  parameter int NUM_TABLES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlpm_pkg::dp_cmd_t                   cmd,
  output tlpm_pkg::dp_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [tlpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlpm_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic [tlpm_pkg::ADDR_W-1:0]         in_virt_addr,
  input  logic [tlpm_pkg::ADDR_W-1:0]         in_phys_addr,
  output logic                                out_valid,
  output logic [tlpm_pkg::STATUS_W-1:0]       out_status,
  output logic [tlpm_pkg::IDX_W-1:0]          out_dir_index,
  output logic [tlpm_pkg::IDX_W-1:0]          out_table_index,
  output logic                                out_table_allocated,
  output logic [tlpm_pkg::ADDR_W-1:0]         out_dir_entry,
  output logic [tlpm_pkg::ADDR_W-1:0]         out_table_entry
);
  import tlpm_pkg::*;

  localparam int TW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int NFW     = $clog2(NUM_TABLES + 1);
  localparam int ROW_W   = 32;
  localparam int BIT_W   = $clog2(ROW_W);
  localparam int MAP_AW  = TW + IDX_W - BIT_W;
  localparam int DIR_N   = 1 << IDX_W;
  localparam int MAP_N   = 1 << MAP_AW;
  localparam int CW      = (MAP_AW > IDX_W) ? MAP_AW : IDX_W;

  // configuration registers
  logic [ADDR_W-1:0] kern_base_r;
  logic [PERM_W-1:0] perms_r;
  logic [PAGE_W-1:0] pool_page_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_base_r <= 32'hC000_0000;
      perms_r     <= 12'h007;
      pool_page_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KERNEL_BASE: kern_base_r <= cfg_wdata;
        REG_USER_PERMS:  perms_r     <= cfg_wdata[PERM_W-1:0];
        REG_POOL_BASE:   pool_page_r <= cfg_wdata[ADDR_W-1:PAGE_SHIFT];
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [CW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear) clr_cnt_r <= clr_cnt_r + CW'(1);
  end

  assign sts.clear_done = &clr_cnt_r;

  // request capture
  logic [PAGE_W-1:0] virt_page_r;
  logic [PAGE_W-1:0] phys_page_r;
  logic              kern_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      virt_page_r <= in_virt_addr[ADDR_W-1:PAGE_SHIFT];
      phys_page_r <= in_phys_addr[ADDR_W-1:PAGE_SHIFT];
      kern_r      <= {in_virt_addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} >= kern_base_r;
    end
  end

  logic [IDX_W-1:0] dir_idx, tix;
  assign dir_idx = virt_page_r[PAGE_W-1:IDX_W];
  assign tix     = virt_page_r[IDX_W-1:0];

  // allocation counter
  logic [NFW-1:0] next_free_r;

  // directory evaluation
  logic [ADDR_W-1:0] dir_rd_r;
  logic [PAGE_W-1:0] tbl_off;
  logic              is_super, is_absent, is_stale, pool_full;
  map_status_t       pre_status;
  logic              alloc_cand;
  logic [TW-1:0]     tbl_sel;

  always_comb begin
    is_super   = (dir_rd_r[PERM_W-1:0] & SUPER_BITS) == SUPER_BITS;
    is_absent  = !dir_rd_r[0];
    tbl_off    = dir_rd_r[ADDR_W-1:PAGE_SHIFT] - pool_page_r;
    is_stale   = tbl_off >= PAGE_W'(next_free_r);
    pool_full  = next_free_r >= NFW'(NUM_TABLES);
    alloc_cand = 1'b0;
    if (kern_r) begin
      pre_status = STS_KERNEL;
    end else if (is_super) begin
      pre_status = STS_SUPERPAGE;
    end else if (is_absent) begin
      pre_status = pool_full ? STS_NO_TABLE : STS_OK;
      alloc_cand = !pool_full;
    end else begin
      pre_status = is_stale ? STS_NO_TABLE : STS_OK;
    end
    tbl_sel = alloc_cand ? next_free_r[TW-1:0] : tbl_off[TW-1:0];
  end

  map_status_t       pre_status_r;
  logic              alloc_r;
  logic [TW-1:0]     table_r;
  logic [ADDR_W-1:0] pde_r;

  always_ff @(posedge clk) begin
    if (cmd.dir_stage) begin
      pre_status_r <= pre_status;
      alloc_r      <= alloc_cand;
      table_r      <= tbl_sel;
      pde_r        <= dir_rd_r;
    end
  end

  // final check and new entries
  logic [ROW_W-1:0]  map_rd_r;
  logic [BIT_W-1:0]  bit_sel;
  logic              is_mapped;
  map_status_t       fin_status;
  logic              commit;
  logic [ROW_W-1:0]  map_row_nxt;
  logic [ADDR_W-1:0] new_pde, new_pte;

  always_comb begin
    bit_sel    = tix[BIT_W-1:0];
    is_mapped  = map_rd_r[bit_sel];
    fin_status = pre_status_r;
    if (pre_status_r == STS_OK && !alloc_r && is_mapped) fin_status = STS_MAPPED;
    commit      = cmd.map_stage && (fin_status == STS_OK);
    map_row_nxt = map_rd_r;
    map_row_nxt[bit_sel] = perms_r[0];
    new_pde = {pool_page_r + PAGE_W'(table_r), perms_r};
    new_pte = {phys_page_r, perms_r};
  end

  // page directory: zeroed by the clearing pass
  logic [ADDR_W-1:0] dir_mem [DIR_N];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      dir_mem[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (commit && alloc_r) begin
      dir_mem[dir_idx] <= new_pde;
    end
    if (cmd.accept) dir_rd_r <= dir_mem[in_virt_addr[ADDR_W-1:ADDR_W-IDX_W]];
  end

  // mapped bitmap: one bit per table entry (written with permission bit 0)
  logic [ROW_W-1:0] map_mem [MAP_N];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      map_mem[clr_cnt_r[MAP_AW-1:0]] <= '0;
    end else if (commit) begin
      map_mem[{table_r, tix[IDX_W-1:BIT_W]}] <= map_row_nxt;
    end
    if (cmd.dir_stage) map_rd_r <= map_mem[{tbl_sel, tix[IDX_W-1:BIT_W]}];
  end

  // allocation counter update
  always_ff @(posedge clk) begin
    if (!rst_n) next_free_r <= '0;
    else if (commit && alloc_r) next_free_r <= next_free_r + NFW'(1);
  end

  // result registers
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.map_stage;
  end

  always_ff @(posedge clk) begin
    if (cmd.map_stage) begin
      out_status          <= fin_status;
      out_dir_index       <= dir_idx;
      out_table_index     <= tix;
      out_table_allocated <= commit && alloc_r;
      out_dir_entry       <= (commit && alloc_r) ? new_pde : pde_r;
      out_table_entry     <= commit ? new_pte : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/two_level_page_map_insert.sv -----
// ----------------------------------------------------------------------------
// two_level_page_map_insert
// Inserts one virtual-to-physical page mapping into a two-level page map.
// ----------------------------------------------------------------------------
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------
//  input   | in_virt_addr, in_phys_addr                    | start & !busy
//  result  | out_status, out_dir_index, out_table_index,   | out_valid, 1 cycle
//          | out_table_allocated, out_dir_entry,           |
//          | out_table_entry                               |
//  config  | cfg_we, cfg_index, cfg_wdata                  | cfg_we
//
// A request passes through a directory read, a mapped-bitmap read, then the
// write-back; one memory port per step. out_valid is registered from the
// write-back step, and a new request can be taken while it is high.
// After reset a clearing pass zeroes every directory entry and bitmap row;
// busy stays high meanwhile.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module two_level_page_map_insert #(
  parameter int NUM_TABLES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tlpm_pkg::ADDR_W-1:0]    in_virt_addr,
  input  logic [tlpm_pkg::ADDR_W-1:0]    in_phys_addr,
  output logic                           out_valid,
  output logic [tlpm_pkg::STATUS_W-1:0]  out_status,
  output logic [tlpm_pkg::IDX_W-1:0]     out_dir_index,
  output logic [tlpm_pkg::IDX_W-1:0]     out_table_index,
  output logic                           out_table_allocated,
  output logic [tlpm_pkg::ADDR_W-1:0]    out_dir_entry,
  output logic [tlpm_pkg::ADDR_W-1:0]    out_table_entry,
  input  logic                           cfg_we,
  input  logic [tlpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlpm_pkg::ADDR_W-1:0]    cfg_wdata
);
  import tlpm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  tlpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // memories and arithmetic
  tlpm_dp #(
    .NUM_TABLES (NUM_TABLES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_virt_addr        (in_virt_addr),
    .in_phys_addr        (in_phys_addr),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_dir_index       (out_dir_index),
    .out_table_index     (out_table_index),
    .out_table_allocated (out_table_allocated),
    .out_dir_entry       (out_dir_entry),
    .out_table_entry     (out_table_entry)
  );

endmodule

// ----- verif/page_map_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_map_checker
// Watches the request, result and register ports of the page map insert
// block, keeps its own copy of the directory and page table pool, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module page_map_checker #(
  parameter int NUM_TABLES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [tlpm_pkg::ADDR_W-1:0]    in_virt_addr,
  input  logic [tlpm_pkg::ADDR_W-1:0]    in_phys_addr,
  input  logic                           out_valid,
  input  logic [tlpm_pkg::STATUS_W-1:0]  out_status,
  input  logic [tlpm_pkg::IDX_W-1:0]     out_dir_index,
  input  logic [tlpm_pkg::IDX_W-1:0]     out_table_index,
  input  logic                           out_table_allocated,
  input  logic [tlpm_pkg::ADDR_W-1:0]    out_dir_entry,
  input  logic [tlpm_pkg::ADDR_W-1:0]    out_table_entry,
  input  logic                           cfg_we,
  input  logic [tlpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlpm_pkg::ADDR_W-1:0]    cfg_wdata,
  output int                             mismatch_count,
  output int                             results_pending
);
  import tlpm_pkg::*;

  localparam int ENTRY_COUNT = NUM_TABLES * 1024;
  localparam logic [ADDR_W-1:0] PAGE_MASK = {{PAGE_W{1'b1}}, {PAGE_SHIFT{1'b0}}};
  localparam logic [ADDR_W-1:0] SUPER_MASK = {{(ADDR_W-PERM_W){1'b0}}, SUPER_BITS};

  typedef struct {
    map_status_t         status;
    logic [IDX_W-1:0]    dir_index;
    logic [IDX_W-1:0]    table_index;
    logic                allocated;
    logic [ADDR_W-1:0]   dir_entry;
    logic [ADDR_W-1:0]   table_entry;
  } map_result_t;

  // register copies
  logic [ADDR_W-1:0] kernel_base;
  logic [PERM_W-1:0] user_perms;
  logic [ADDR_W-1:0] pool_base;

  // shadow page map
  logic [ADDR_W-1:0] dir_mem [1024];
  bit                entry_written [ENTRY_COUNT];
  logic [ADDR_W-1:0] entry_mem [ENTRY_COUNT];
  int                tables_taken;

  map_result_t expected_maps[$];
  map_result_t oldest;

  // Predicts one insert and commits its effect on the shadow map
  function automatic map_result_t predict_mapping(logic [ADDR_W-1:0] virt,
                                                  logic [ADDR_W-1:0] phys);
    map_result_t       r;
    logic [ADDR_W-1:0] vpage;
    logic [ADDR_W-1:0] perms;
    logic [ADDR_W-1:0] pde;
    logic [ADDR_W-1:0] offset;
    logic [PAGE_W-1:0] tbl;
    int                slot;
    vpage         = virt & PAGE_MASK;
    perms         = {{(ADDR_W-PERM_W){1'b0}}, user_perms};
    pde           = dir_mem[virt[31:22]];
    tbl           = '0;
    r.status      = STS_OK;
    r.dir_index   = virt[31:22];
    r.table_index = virt[21:12];
    r.allocated   = 1'b0;
    r.table_entry = '0;

    // kernel space, superpage, absent directory entry, then the table entry
    if (vpage >= kernel_base) begin
      r.status = STS_KERNEL;
    end else if ((pde & SUPER_MASK) == SUPER_MASK) begin
      r.status = STS_SUPERPAGE;
    end else if (!pde[0]) begin
      if (tables_taken >= NUM_TABLES) begin
        r.status = STS_NO_TABLE;
      end else begin
        tbl         = PAGE_W'(tables_taken);
        r.allocated = 1'b1;
      end
    end else begin
      // pointer relative to the current pool base, 32-bit wrap
      offset = (pde & PAGE_MASK) - (pool_base & PAGE_MASK);
      tbl    = offset[ADDR_W-1:PAGE_SHIFT];
      if (tbl >= tables_taken) begin
        r.status = STS_NO_TABLE;
      end else begin
        slot = int'(tbl) * 1024 + int'(virt[21:12]);
        if (entry_written[slot] && entry_mem[slot][0]) r.status = STS_MAPPED;
      end
    end

    // commit on success only
    if (r.status == STS_OK) begin
      slot = int'(tbl) * 1024 + int'(virt[21:12]);
      if (r.allocated) begin
        pde = ((pool_base & PAGE_MASK) + {tbl, {PAGE_SHIFT{1'b0}}}) | perms;
        dir_mem[virt[31:22]] = pde;
        tables_taken++;
      end
      r.table_entry       = (phys & PAGE_MASK) | perms;
      entry_mem[slot]     = r.table_entry;
      entry_written[slot] = 1'b1;
    end
    r.dir_entry = pde;
    return r;
  endfunction

  // Compare results, track register writes, predict accepted transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      kernel_base  = 32'hC000_0000;
      user_perms   = 12'h007;
      pool_base    = '0;
      tables_taken = 0;
      foreach (dir_mem[i]) dir_mem[i] = '0;
      foreach (entry_written[i]) entry_written[i] = 1'b0;
      expected_maps.delete();
      mismatch_count  = 0;
      results_pending = 0;
    end else begin
      if (out_valid) begin
        if (expected_maps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR %0t: result with no request pending: sts=%0d dir=%0d tbl=%0d",
                     $time, out_status, out_dir_index, out_table_index);
        end else begin
          oldest = expected_maps.pop_front();
          if (out_status !== oldest.status || out_dir_index !== oldest.dir_index ||
              out_table_index !== oldest.table_index ||
              out_table_allocated !== oldest.allocated ||
              out_dir_entry !== oldest.dir_entry ||
              out_table_entry !== oldest.table_entry) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR %0t: exp sts=%0d dir=%0d tbl=%0d alloc=%0b pde=%h pte=%h",
                       $time, oldest.status, oldest.dir_index, oldest.table_index,
                       oldest.allocated, oldest.dir_entry, oldest.table_entry);
              $display("         got sts=%0d dir=%0d tbl=%0d alloc=%0b pde=%h pte=%h",
                       out_status, out_dir_index, out_table_index,
                       out_table_allocated, out_dir_entry, out_table_entry);
            end
          end
        end
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KERNEL_BASE: kernel_base = cfg_wdata;
          REG_USER_PERMS:  user_perms  = cfg_wdata[PERM_W-1:0];
          REG_POOL_BASE:   pool_base   = cfg_wdata;
          default: ;
        endcase
      end

      if (start && !busy) expected_maps.push_back(predict_mapping(in_virt_addr, in_phys_addr));
      results_pending = expected_maps.size();
    end
  end

endmodule

// ----- verif/tb_two_level_page_map_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_page_map_insert
// Drives map requests and register settings into the page map insert block:
// a directed pass over the rejection cases, stale pointers and permission
// corners, then randomized phases focused on a small set of directory slots.
// ----------------------------------------------------------------------------
module tb_two_level_page_map_insert;
  import tlpm_pkg::*;

  localparam int NUM_TABLES    = 16;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOT_DIRS      = 16;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     in_virt_addr;
  logic [ADDR_W-1:0]     in_phys_addr;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_dir_index;
  logic [IDX_W-1:0]      out_table_index;
  logic                  out_table_allocated;
  logic [ADDR_W-1:0]     out_dir_entry;
  logic [ADDR_W-1:0]     out_table_entry;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_wdata;
  int                    mismatch_count;
  int                    results_pending;
  int                    cycle_count;
  logic [IDX_W-1:0]      hot_dirs [HOT_DIRS];

  two_level_page_map_insert #(.NUM_TABLES(NUM_TABLES)) uut (.*);

  page_map_checker #(.NUM_TABLES(NUM_TABLES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one request transaction; start stays high until the block takes it
  task automatic send_request(logic [ADDR_W-1:0] virt, logic [ADDR_W-1:0] phys);
    @(negedge clk);
    start        <= 1'b1;
    in_virt_addr <= virt;
    in_phys_addr <= phys;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // hold off until every pending result is back, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic set_map_config(logic [ADDR_W-1:0] kbase, logic [ADDR_W-1:0] perms,
                                logic [ADDR_W-1:0] pool);
    drain_results();
    write_reg(REG_KERNEL_BASE, kbase);
    write_reg(REG_USER_PERMS, perms);
    write_reg(REG_POOL_BASE, pool);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] kbase;
    logic [ADDR_W-1:0] perms;
    logic [ADDR_W-1:0] pool;
    logic [ADDR_W-1:0] virt;
    bit                calm;
    int                gap;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_virt_addr = '0;
    in_phys_addr = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_KERNEL_BASE;
    cfg_wdata    = '0;
    cycle_count  = 0;

    // slots the random part keeps coming back to
    hot_dirs[0] = 10'd0;
    hot_dirs[1] = 10'd767;
    hot_dirs[2] = 10'd1023;
    hot_dirs[3] = 10'd5;
    hot_dirs[4] = 10'd2;
    for (int i = 5; i < HOT_DIRS; i++) hot_dirs[i] = IDX_W'($urandom_range(1, 766));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first table, repeat hit, second page, top of user space
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0FFF, 32'hFFFF_FFFF);
    send_request(32'h0000_1000, 32'hFFFF_FFFF);
    send_request(32'hBFFF_FFFF, 32'h1234_5000);
    send_request(32'hC000_0000, 32'h5555_5555);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'hBFFF_F000, 32'hAAAA_AAAA);

    // nothing is kernel; full permissions make new directory entries superpages
    set_map_config(32'hFFFF_FFFF, 32'h0000_0FFF, 32'h0000_0000);
    send_request(32'hFFFF_F000, 32'h8000_0000);
    send_request(32'hFFC0_0000, 32'h0000_1000);
    send_request(32'h0000_2000, 32'h7FFF_F000);

    // permissions without the present bit: each request takes another table
    set_map_config(32'hC000_0000, 32'h0000_0006, 32'h0000_0000);
    send_request(32'h0140_0000, 32'h0F0F_0000);
    send_request(32'h0140_1000, 32'hF0F0_F000);

    // moved pool base: existing pointers go stale
    set_map_config(32'hC000_0000, 32'h0000_0007, 32'h0010_0000);
    send_request(32'h0000_3000, 32'h3333_3000);
    send_request(32'hBFC0_0000, 32'h4444_4000);
    send_request(32'h0080_0000, 32'h6666_6000);

    // pool base at the top wraps back onto taken tables
    set_map_config(32'hC000_0000, 32'h0000_0007, 32'hFFFF_FFFF);
    send_request(32'h0000_4000, 32'h9999_9000);

    // everything is kernel space
    set_map_config(32'h0000_0000, 32'h0000_0007, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h1234_5678, 32'h8765_4321);

    // randomized phases, each with its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kbase = 32'hC000_0000;
        6:                kbase = 32'hFFFF_FFFF;
        7:                kbase = 32'h0000_0000;
        default:          kbase = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: perms = 32'h0000_0007;
        6:                perms = 32'h0000_0FFF;
        7:                perms = $urandom;
        8:                perms = 32'h0000_0001;
        default:          perms = ($urandom & 32'hFFFF_FF7F) | 32'h1;
      endcase
      case ($urandom_range(0, 9))
        8:       pool = $urandom;
        9:       pool = 32'hFFFF_F000;
        default: pool = 32'h0000_0000;
      endcase
      set_map_config(kbase, perms, pool);
      calm = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mostly hot slots with few table indexes, so entries get revisited
        if ($urandom_range(0, 99) < 80)
          virt = {hot_dirs[$urandom_range(0, HOT_DIRS-1)],
                  IDX_W'($urandom_range(0, 31)), PAGE_SHIFT'($urandom)};
        else
          virt = $urandom;
        send_request(virt, $urandom);

        if (!calm) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
            12, 13, 14, 15, 16, 17:               gap = $urandom_range(1, 3);
            default:                              gap = $urandom_range(10, 40);
          endcase
          idle_cycles(gap);
        end
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tlpm_pkg.sv
hw/rtl/tlpm_ctrl.sv
hw/rtl/tlpm_dp.sv
hw/rtl/two_level_page_map_insert.sv
verif/page_map_checker.sv
verif/tb_two_level_page_map_insert.sv
